// File: hw/rtl/lpft_pkg.sv
// Shared constants and types for the LRU page frame table.
`timescale 1ns / 1ps

package lpft_pkg;

   localparam int FRAME_COUNT = 4;
   localparam int PAGE_W = 32;
   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam int TOTAL_W = 32;
   localparam int FRAME_FIELD_W = 2;
   localparam int RSP_FIELDS_W = FRAME_FIELD_W + PAGE_W + 2 * TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   // Contents handed from one cell to the next, toward the LRU end.
   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
      logic [IDX_W-1:0]  frame;
   } entry_type;

   // Match summary handed from the LRU end toward the MRU end.
   typedef struct packed {
      logic             sel;
      logic [IDX_W-1:0] frame;
   } match_type;

endpackage

// File: hw/rtl/lru_page_frame_table_unit.sv
// Top level of the LRU page frame table: cell chain, counters and result register.
`timescale 1ns / 1ps

// Each request item carries a 32-bit page number, and one result item comes back per
// request, in the cycle after acceptance. The table is a chain of FRAME_COUNT cells
// kept in recency order: cell 0 holds the most recently used page and the last cell
// the least recently used one. Every cell compares its page with the request in the
// same cycle; on a hit the cells from the MRU end down to the hit cell shift by one
// and the page re-enters at cell 0, on a miss the whole chain shifts and the page
// falling off the LRU end is the evicted one. Unused frames are handed out in order
// until all are in use. A new item is accepted every cycle whenever the result
// register is empty or its result is taken in the same cycle, so the sustained rate is
// one item per cycle while results are taken, set by the cell chain's compare and shift.
// The 32-bit hit and miss totals wrap and count the current request.

module lru_page_frame_table_unit
   import lpft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PAGE_W-1:0]     req_tdata,  // [31:0] page_number
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // frame_index, evicted_page, hit_total,
                                             // miss_total, zero padding
   output logic [RSP_USER_W-1:0] rsp_tuser   // [0] hit, [1] evicted
);

   entry_type entry_link [0:FRAME_COUNT];
   match_type match_link [0:FRAME_COUNT];
   logic [FRAME_COUNT-1:0] valid_vec;

   logic               take;
   logic               hit;
   logic               full;
   logic [IDX_W-1:0]   new_frame;
   logic [CNT_W-1:0]   frames_used_ff, frames_used_in;
   logic [TOTAL_W-1:0] hit_count_ff, hit_count_in;
   logic [TOTAL_W-1:0] miss_count_ff, miss_count_in;

   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic                     rsp_evicted_ff;
   logic [FRAME_FIELD_W-1:0] rsp_frame_ff;
   logic [PAGE_W-1:0]        rsp_victim_ff;
   logic [TOTAL_W-1:0]       rsp_hit_total_ff;
   logic [TOTAL_W-1:0]       rsp_miss_total_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;

   // The match summary leaving cell 0 covers the whole chain.
   assign hit = match_link[0].sel;
   assign full = entry_link[FRAME_COUNT].valid;

   // Frame for the page entering cell 0: the hit frame, the next unused frame,
   // or the frame of the page leaving the LRU end.
   always_comb begin
      if (hit) begin
         new_frame = match_link[0].frame;
      end else if (full) begin
         new_frame = entry_link[FRAME_COUNT].frame;
      end else begin
         new_frame = frames_used_ff[IDX_W-1:0];
      end
   end

   assign entry_link[0].valid = 1'b1;
   assign entry_link[0].page = req_tdata;
   assign entry_link[0].frame = new_frame;
   assign match_link[FRAME_COUNT] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < FRAME_COUNT; gi++) begin : g_cell
         lpft_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .take      (take),
            .miss      (!hit),
            .req_page  (req_tdata),
            .up_in     (entry_link[gi]),
            .down_out  (entry_link[gi+1]),
            .match_in  (match_link[gi+1]),
            .match_out (match_link[gi])
         );
         assign valid_vec[gi] = entry_link[gi+1].valid;
      end
   endgenerate

   always_comb begin
      frames_used_in = frames_used_ff;
      hit_count_in = hit_count_ff;
      miss_count_in = miss_count_ff;
      if (take) begin
         if (hit) begin
            hit_count_in = hit_count_ff + 1'b1;
         end else begin
            miss_count_in = miss_count_ff + 1'b1;
            if (!full) begin
               frames_used_in = frames_used_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_used_ff <= '0;
         hit_count_ff <= '0;
         miss_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frames_used_ff <= frames_used_in;
         hit_count_ff <= hit_count_in;
         miss_count_ff <= miss_count_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_hit_ff <= hit;
         rsp_evicted_ff <= !hit && full;
         rsp_frame_ff <= FRAME_FIELD_W'(new_frame);
         rsp_victim_ff <= (!hit && full) ? entry_link[FRAME_COUNT].page : '0;
         rsp_hit_total_ff <= hit_count_in;
         rsp_miss_total_ff <= miss_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = {rsp_evicted_ff, rsp_hit_ff};
   assign rsp_tdata = RSP_DATA_W'({rsp_miss_total_ff, rsp_hit_total_ff,
                                   rsp_victim_ff, rsp_frame_ff});

   // The in-use cells always form an unbroken run from the MRU end.
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(frames_used_ff))
      else $error("frame count disagrees with occupied cells");

   assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("occupied cells are not contiguous");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("result marks both hit and eviction");

   assert property (@(posedge clock) disable iff (reset)
      (take && !hit && !full) |=> (frames_used_ff == $past(frames_used_ff) + 1'b1))
      else $error("fill miss did not claim a frame");

endmodule

// File: hw/rtl/lpft_cell.sv
// One recency-ordered slot of the page frame table.
`timescale 1ns / 1ps

module lpft_cell
   import lpft_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic              miss,
   input  logic [PAGE_W-1:0] req_page,
   input  entry_type         up_in,
   output entry_type         down_out,
   input  match_type         match_in,
   output match_type         match_out
);

   logic              valid_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [IDX_W-1:0]  frame_ff;
   logic              match;
   logic              shift;

   // A cell shifts when the hit lies here or further toward the LRU end,
   // or on any miss.
   assign match = valid_ff && (page_ff == req_page);
   assign match_out.sel = match | match_in.sel;
   assign match_out.frame = match_in.frame | (match ? frame_ff : '0);
   assign shift = take && (miss || match_out.sel);

   assign down_out.valid = valid_ff;
   assign down_out.page = page_ff;
   assign down_out.frame = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= up_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         page_ff <= up_in.page;
         frame_ff <= up_in.frame;
      end
   end

endmodule

// File: verif/tb_lru_page_frame_table_unit.sv
// Self-checking testbench for the LRU page frame table unit.
`timescale 1ns / 1ps

module tb_lru_page_frame_table_unit
   import lpft_pkg::*;
();

   // Fields of one lookup result.
   typedef struct {
      logic                     hit;
      logic [FRAME_FIELD_W-1:0] frame;
      logic                     evicted;
      logic [PAGE_W-1:0]        victim;
      logic [TOTAL_W-1:0]       hits;
      logic [TOTAL_W-1:0]       misses;
   } lookup_result_type;

   localparam int WORKING_SET_PAGES = 6;
   localparam int PHASE_ITEMS = 238;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_LIMIT = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PAGE_W-1:0]     req_tdata = '0;   // [31:0] page_number
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // frame_index, evicted_page, hit_total,
                                            // miss_total, zero padding
   logic [RSP_USER_W-1:0] rsp_tuser;        // [0] hit, [1] evicted

   lru_page_frame_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Shadow copy of the table. Only entries below frames_in_use are ever read, so the
   // unwritten entries never matter.
   logic [PAGE_W-1:0]  frame_page [FRAME_COUNT];
   int                 frame_age [FRAME_COUNT];   // 0 is most recently used
   int                 frames_in_use = 0;
   logic [TOTAL_W-1:0] hit_count = '0;
   logic [TOTAL_W-1:0] miss_count = '0;

   // Results still owed by the block, oldest first.
   lookup_result_type pending_lookups[$];

   int mismatch_count = 0;
   int error_count = 0;

   // Idling controls. A calm stretch turns off idling on both sides for a while so that
   // back-to-back traffic appears inside every phase.
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  calm = 1'b0;

   logic [PAGE_W-1:0] page_pool [WORKING_SET_PAGES];

   // Look one page up in the shadow table and return what the block must answer. A hit
   // ages only the frames that were more recent than the hit frame; a miss ages every
   // used frame. With the table full, the frame ranked last loses its page.
   function automatic lookup_result_type lookup_page(input logic [PAGE_W-1:0] page);
      lookup_result_type r;
      int                slot;
      bit                found;
      int                limit;
      r = '{default: '0};
      slot = 0;
      found = 1'b0;
      for (int i = 0; i < frames_in_use; i++) begin
         if (!found && frame_page[i] == page) begin
            slot = i;
            found = 1'b1;
         end
      end
      if (found) begin
         hit_count = hit_count + 1'b1;
         limit = frame_age[slot];
      end else begin
         miss_count = miss_count + 1'b1;
         limit = FRAME_COUNT;
         if (frames_in_use < FRAME_COUNT) begin
            slot = frames_in_use;
            frames_in_use++;
         end else begin
            slot = -1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (slot < 0 && frame_age[i] == FRAME_COUNT - 1)
                  slot = i;
            end
            if (slot < 0)
               slot = 0;
            r.evicted = 1'b1;
            r.victim = frame_page[slot];
         end
         frame_page[slot] = page;
      end
      for (int i = 0; i < frames_in_use; i++) begin
         if (i != slot && frame_age[i] < limit)
            frame_age[i]++;
      end
      frame_age[slot] = 0;
      r.hit = found;
      r.frame = FRAME_FIELD_W'(slot);
      r.hits = hit_count;
      r.misses = miss_count;
      return r;
   endfunction

   // Offer one page, idling first at the current rate, and record the expected result
   // at the edge where the block takes it. The valid stays high afterwards, so the next
   // call can follow in the same step without lowering it.
   task automatic send_page(input logic [PAGE_W-1:0] page);
      while (!calm && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= page;
      do
         @(posedge clock);
      while (!req_tready);
      pending_lookups.push_back(lookup_page(page));
   endtask

   // Withdraw the request and wait until every result owed has come back.
   task automatic wait_all_returned();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0)
         @(posedge clock);
   endtask

   // Receiver side: stall at the current rate, decided anew every cycle.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s expected 0x%08h, got 0x%08h", $realtime, name, want, got);
      end
   endfunction

   // Compare every result taken with the oldest expectation, field by field.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lookups.size() == 0) begin
            error_count++;
            if (error_count + mismatch_count <= REPORT_LIMIT)
               $display("%0t: result item with no request outstanding", $realtime);
         end else begin
            want = pending_lookups.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_tuser[0]));
            check_field("evicted", 32'(want.evicted), 32'(rsp_tuser[1]));
            check_field("frame_index", 32'(want.frame), 32'(rsp_tdata[1:0]));
            check_field("evicted_page", want.victim, rsp_tdata[33:2]);
            check_field("hit_total", want.hits, rsp_tdata[65:34]);
            check_field("miss_total", want.misses, rsp_tdata[97:66]);
         end
      end
   end

   // Fill the table from empty with pages at the extremes of the field, hit it at the
   // most and least recent positions and in the middle, then force evictions, including
   // the return of a page that was just evicted and a repeat of the same page.
   task automatic test_fill_hit_evict();
      send_page(32'h0000_0000);   // first miss into frame 0
      send_page(32'h0000_0000);   // hit on the only, most recent page
      send_page(32'hFFFF_FFFF);
      send_page(32'h1234_5678);
      send_page(32'hEDCB_A987);   // table now full
      send_page(32'h1234_5678);   // hit in the middle of the order
      send_page(32'h0000_0000);   // hit on the least recent page
      send_page(32'h8000_0001);   // miss with the table full evicts the last one
      send_page(32'hFFFF_FFFF);   // the evicted page comes back and evicts again
      send_page(32'h0000_0001);   // one bit away from a resident page
      send_page(32'h7FFF_FFFE);
      send_page(32'h7FFF_FFFE);
      send_page(32'h7FFF_FFFE);
      send_page(32'h0000_0001);
      send_page(32'h8000_0001);
      send_page(32'hFFFF_FFFF);
      send_page(32'h0000_0000);
   endtask

   // Stop sending until the block has answered everything, then go on with hits and
   // misses on the table as it stands.
   task automatic test_pause_until_idle();
      send_page(page_pool[0]);
      send_page(page_pool[1]);
      send_page(page_pool[0]);
      wait_all_returned();
      send_page(page_pool[1]);
      send_page(page_pool[2]);
   endtask

   function automatic logic [PAGE_W-1:0] random_page();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75)
         return page_pool[$urandom_range(WORKING_SET_PAGES - 1)];
      else if (roll < 87)
         return page_pool[$urandom_range(WORKING_SET_PAGES - 1)]
                ^ (32'h1 << $urandom_range(31));
      else
         return $urandom;
   endfunction

   // A working set a little larger than the table keeps hits, fills and evictions all
   // frequent; near misses and fresh pages are mixed in, and the set drifts slowly.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int count);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < WORKING_SET_PAGES; i++)
         page_pool[i] = $urandom;
      for (int n = 0; n < count; n++) begin
         calm = (n % 60) >= 45;
         if ($urandom_range(99) < 3)
            page_pool[$urandom_range(WORKING_SET_PAGES - 1)] = $urandom;
         send_page(random_page());
      end
      calm = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < WORKING_SET_PAGES; i++)
         page_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_fill_hit_evict();
      test_pause_until_idle();
      test_random_traffic(0, 0, PHASE_ITEMS);
      test_random_traffic(86, 0, PHASE_ITEMS);
      test_random_traffic(0, 86, PHASE_ITEMS);
      test_random_traffic(16, 16, PHASE_ITEMS);

      wait_all_returned();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
